@@ hw/rtl/cpsi_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar period slot index block.
package cpsi_pkg;

  typedef logic [3:0] pcode_t;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned NUM_PCODES   = 10;
  localparam int unsigned LATENCY      = 11;
  localparam int unsigned LEN_FRAC     = 28;

  localparam logic [2:0] KIND_DAY   = 3'd0;
  localparam logic [2:0] KIND_WEEK  = 3'd1;
  localparam logic [2:0] KIND_MONTH = 3'd2;
  localparam logic [2:0] KIND_YEAR  = 3'd3;
  localparam logic [2:0] KIND_BLOCK = 3'd4;

  localparam pcode_t P_DAY   = 4'd0;
  localparam pcode_t P_WEEK  = 4'd1;
  localparam pcode_t P_M28   = 4'd2;
  localparam pcode_t P_M29   = 4'd3;
  localparam pcode_t P_M30   = 4'd4;
  localparam pcode_t P_M31   = 4'd5;
  localparam pcode_t P_Y365  = 4'd6;
  localparam pcode_t P_Y366  = 4'd7;
  localparam pcode_t P_B1826 = 4'd8;
  localparam pcode_t P_B1827 = 4'd9;

  localparam int unsigned PERIOD_DAYS [NUM_PCODES] = '{
    1, 7, 28, 29, 30, 31, 365, 366, 1826, 1827
  };

  // Days from 1970-01-01 to January 1st of year 1970+n; valid up to 2200.
  function automatic logic [15:0] year_start(input logic [7:0] n);
    logic [15:0] base;
    logic [7:0]  n1;
    base = 16'(16'(n) * 16'd365);
    n1   = n + 8'd1;
    return base + 16'(n1[7:2]) - 16'(n >= 8'd131);
  endfunction

  // Day of year of the first day of month m (0 = January) in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Period code of month m (0 = January).
  function automatic pcode_t month_code(input logic [3:0] m, input logic leap);
    pcode_t r;
    case (m)
      4'd1:                      r = leap ? P_M29 : P_M28;
      4'd3, 4'd5, 4'd8, 4'd10:   r = P_M30;
      default:                   r = P_M31;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/calendar_period_slot_index.sv @@
// Calendar period slot index: timestamp to slot of its day, week, month, year or five-year block.
//
// Usage: drive in_timestamp (UTC epoch seconds) and in_period_kind and pulse start.
// A transaction is taken at each rising edge with start high and busy low; busy
// stays low, so a new transaction may enter every cycle.
// Each transaction returns one result: out_valid is high for exactly one cycle
// with out_slot_index, out_slot_start and out_slot_end. Throughput is one
// transaction per cycle.
// The 11 stages: day split, correction, year estimate and weekday, year fix,
// day of year, month search and five-year block, kind select, period offset,
// reciprocal multiply, slot multiply, remainder fix and slot bounds.
// The receiver cannot stall; results appear in input order.
// Synchronous reset drops all transactions in flight; no storage needs clearing.
module calendar_period_slot_index #(
  parameter int unsigned SLOTS_PER_PERIOD = 200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_period_kind,
  input  logic [31:0]        in_timestamp,
  output logic               out_valid,
  output logic [8:0]         out_slot_index,
  output logic signed [32:0] out_slot_start,
  output logic signed [33:0] out_slot_end
);

  localparam int unsigned NP = cpsi_pkg::NUM_PCODES;
  localparam int unsigned LF = cpsi_pkg::LEN_FRAC;

  logic [LF-1:0] slot_len_tab [NP];
  logic [LF:0]   slot_rcp_tab [NP];

  for (genvar g = 0; g < NP; g++) begin : g_len
    localparam longint unsigned SECS =
      longint'(cpsi_pkg::PERIOD_DAYS[g]) * longint'(cpsi_pkg::SECS_PER_DAY);
    localparam longint unsigned LEN_RAW = SECS / SLOTS_PER_PERIOD;
    localparam longint unsigned LEN = (LEN_RAW > 0) ? LEN_RAW : 1;
    localparam longint unsigned RCP = (64'd1 << LF) / LEN;
    assign slot_len_tab[g] = LF'(LEN);
    assign slot_rcp_tab[g] = (LF+1)'(RCP);
  end

  logic [10:0] vld_r;
  logic        take;

  assign busy = 1'b0;
  assign take = start && !busy;
  assign out_valid = vld_r[10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[9:0], take};
    end
  end

  // stage 1: day estimate
  logic [31:0] ts1_r, ts2_r, ts3_r, ts4_r, ts5_r, ts6_r, ts7_r;
  logic [2:0]  kind1_r, kind2_r, kind3_r, kind4_r, kind5_r, kind6_r;
  logic [15:0] dq1_r, dq1_nxt;

  assign dq1_nxt = 16'((48'(in_timestamp) * 48'd49710) >> 32);

  // stage 2: day correction
  logic [31:0] rem2;
  logic [15:0] days2_r, days2_nxt;

  assign rem2 = ts1_r - 32'(32'(dq1_r) * 32'(cpsi_pkg::SECS_PER_DAY));
  assign days2_nxt = dq1_r + 16'(rem2 >= 32'(cpsi_pkg::SECS_PER_DAY));

  // stage 3: year estimate and weekday quotient
  logic [15:0] days3_r;
  logic [7:0]  nest3_r, nest3_nxt;
  logic [16:0] x3;
  logic [15:0] q7_3_r, q7_3_nxt;

  assign nest3_nxt = 8'((32'(days2_r) * 32'd45933) >> 24);
  assign x3        = 17'(days2_r) + 17'd4;
  assign q7_3_nxt  = 16'((36'(x3) * 36'd149797) >> 20);

  // stage 4: year fix and week start
  logic [15:0]        days4_r;
  logic [7:0]         n4_r, n4_nxt;
  logic [2:0]         dow4;
  logic signed [17:0] wk4_r, wk4_nxt;

  assign n4_nxt  = nest3_r + 8'(cpsi_pkg::year_start(nest3_r + 8'd1) <= days3_r);
  assign dow4    = 3'(17'(days3_r) + 17'd4 - 17'(17'(q7_3_r) * 17'd7));
  assign wk4_nxt = $signed({2'b00, days3_r}) - $signed({15'd0, dow4});

  // stage 5: day of year, leap flag, block quotient
  logic [15:0]        days5_r, ys5_r, ys5_nxt;
  logic signed [17:0] wk5_r;
  logic [8:0]         doy5_r, doy5_nxt;
  logic               leap5_r, leap5_nxt;
  logic [4:0]         q5_5_r, q5_5_nxt;
  logic [7:0]         n4p2;

  assign ys5_nxt   = cpsi_pkg::year_start(n4_r);
  assign doy5_nxt  = 9'(days4_r - ys5_nxt);
  assign n4p2      = n4_r + 8'd2;
  assign leap5_nxt = (n4p2[1:0] == 2'd0) && (n4_r != 8'd130);
  assign q5_5_nxt  = 5'((16'(n4_r) * 16'd205) >> 10);

  // stage 6: month search and five-year block
  logic [15:0]        days6_r, ys6_r, mday6_r, mday6_nxt, bstart6_r, bstart6_nxt;
  logic signed [17:0] wk6_r;
  cpsi_pkg::pcode_t   mcode6_r, mcode6_nxt, ycode6_r, bcode6_r, bcode6_nxt;
  logic [3:0]         midx6;
  logic [7:0]         blk6;
  logic [15:0]        bdays6;

  always_comb begin
    midx6 = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy5_r >= cpsi_pkg::month_start(4'(i)) + 9'(leap5_r && (i >= 2))) begin
        midx6 = midx6 + 4'd1;
      end
    end
  end

  assign mday6_nxt = ys5_r + 16'(cpsi_pkg::month_start(midx6) +
                                 9'(leap5_r && (midx6 >= 4'd2)));
  assign mcode6_nxt  = cpsi_pkg::month_code(midx6, leap5_r);
  assign blk6        = 8'(8'(q5_5_r) * 8'd5);
  assign bstart6_nxt = cpsi_pkg::year_start(blk6);
  assign bdays6      = cpsi_pkg::year_start(blk6 + 8'd5) - bstart6_nxt;
  assign bcode6_nxt  = (bdays6 == 16'd1827) ? cpsi_pkg::P_B1827 : cpsi_pkg::P_B1826;

  // stage 7: select period by kind
  logic signed [17:0] sday7_r, sday7_nxt;
  cpsi_pkg::pcode_t   pcode7_r, pcode7_nxt;

  always_comb begin
    case (kind6_r)
      cpsi_pkg::KIND_WEEK: begin
        sday7_nxt  = wk6_r;
        pcode7_nxt = cpsi_pkg::P_WEEK;
      end
      cpsi_pkg::KIND_MONTH: begin
        sday7_nxt  = $signed({2'b00, mday6_r});
        pcode7_nxt = mcode6_r;
      end
      cpsi_pkg::KIND_YEAR: begin
        sday7_nxt  = $signed({2'b00, ys6_r});
        pcode7_nxt = ycode6_r;
      end
      cpsi_pkg::KIND_BLOCK: begin
        sday7_nxt  = $signed({2'b00, bstart6_r});
        pcode7_nxt = bcode6_r;
      end
      default: begin
        sday7_nxt  = $signed({2'b00, days6_r});
        pcode7_nxt = cpsi_pkg::P_DAY;
      end
    endcase
  end

  // stage 8: period start in seconds and offset
  logic signed [33:0] ssec8_r, ssec8_nxt, ssec9_r, ssec10_r;
  logic signed [34:0] diff8;
  logic [LF-1:0]      off8_r, off8_nxt, off9_r, off10_r;
  cpsi_pkg::pcode_t   pcode8_r, pcode9_r, pcode10_r;

  assign ssec8_nxt = 34'(34'(sday7_r) * $signed(34'(cpsi_pkg::SECS_PER_DAY)));
  assign diff8     = $signed({3'b000, ts7_r}) - 35'(ssec8_nxt);
  assign off8_nxt  = LF'(diff8);

  // stage 9: quotient estimate
  logic [9:0] q9_r, q9_nxt, q10_r;

  assign q9_nxt = 10'(((2*LF+1)'(off8_r) * (2*LF+1)'(slot_rcp_tab[pcode8_r])) >> LF);

  // stage 10: quotient times slot length
  logic [LF-1:0] ql10_r, ql10_nxt;

  assign ql10_nxt = LF'(LF'(q9_r) * slot_len_tab[pcode9_r]);

  // stage 11: remainder fix and slot bounds
  logic [LF-1:0]      len11, rem11;
  logic               corr11;
  logic signed [33:0] lo11, hi11, base11;
  logic [9:0]         q11;

  assign len11  = slot_len_tab[pcode10_r];
  assign rem11  = off10_r - ql10_r;
  assign corr11 = rem11 >= len11;
  assign q11    = q10_r + 10'(corr11);
  assign base11 = ssec10_r + $signed({6'd0, ql10_r});
  assign lo11   = base11 + (corr11 ? $signed({6'd0, len11}) : 34'sd0);
  assign hi11   = base11 + (corr11 ? $signed({5'd0, len11, 1'b0}) : $signed({6'd0, len11}));

  always_ff @(posedge clk) begin
    ts1_r    <= in_timestamp;
    kind1_r  <= in_period_kind;
    dq1_r    <= dq1_nxt;

    ts2_r    <= ts1_r;
    kind2_r  <= kind1_r;
    days2_r  <= days2_nxt;

    ts3_r    <= ts2_r;
    kind3_r  <= kind2_r;
    days3_r  <= days2_r;
    nest3_r  <= nest3_nxt;
    q7_3_r   <= q7_3_nxt;

    ts4_r    <= ts3_r;
    kind4_r  <= kind3_r;
    days4_r  <= days3_r;
    n4_r     <= n4_nxt;
    wk4_r    <= wk4_nxt;

    ts5_r    <= ts4_r;
    kind5_r  <= kind4_r;
    days5_r  <= days4_r;
    wk5_r    <= wk4_r;
    ys5_r    <= ys5_nxt;
    doy5_r   <= doy5_nxt;
    leap5_r  <= leap5_nxt;
    q5_5_r   <= q5_5_nxt;

    ts6_r     <= ts5_r;
    kind6_r   <= kind5_r;
    days6_r   <= days5_r;
    wk6_r     <= wk5_r;
    ys6_r     <= ys5_r;
    ycode6_r  <= leap5_r ? cpsi_pkg::P_Y366 : cpsi_pkg::P_Y365;
    mday6_r   <= mday6_nxt;
    mcode6_r  <= mcode6_nxt;
    bstart6_r <= bstart6_nxt;
    bcode6_r  <= bcode6_nxt;

    ts7_r    <= ts6_r;
    sday7_r  <= sday7_nxt;
    pcode7_r <= pcode7_nxt;

    ssec8_r  <= ssec8_nxt;
    off8_r   <= off8_nxt;
    pcode8_r <= pcode7_r;

    ssec9_r  <= ssec8_r;
    off9_r   <= off8_r;
    pcode9_r <= pcode8_r;
    q9_r     <= q9_nxt;

    ssec10_r  <= ssec9_r;
    off10_r   <= off9_r;
    pcode10_r <= pcode9_r;
    q10_r     <= q9_r;
    ql10_r    <= ql10_nxt;

    out_slot_index <= q11[8:0];
    out_slot_start <= 33'(lo11);
    out_slot_end   <= hi11;
  end

endmodule

@@ hw/rtl/cpsi_check.sv @@
// Port-level checker for the calendar period slot index block, with its bind.
module cpsi_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_period_kind,
  input logic [31:0]        in_timestamp,
  input logic               out_valid,
  input logic [8:0]         out_slot_index,
  input logic signed [32:0] out_slot_start,
  input logic signed [33:0] out_slot_end
);

  localparam int unsigned LAT = cpsi_pkg::LATENCY;

  a_result_has_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a transaction taken at the pipeline latency");

  a_slot_holds_timestamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (34'(out_slot_start) <= $signed({2'b00, $past(in_timestamp, LAT)})) &&
      ($signed({2'b00, $past(in_timestamp, LAT)}) < out_slot_end))
    else $error("slot bounds do not enclose the transaction timestamp");

  a_slot_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slot_end > 34'(out_slot_start)))
    else $error("slot end not after slot start");

  a_start_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slot_start >= -33'sd345600))
    else $error("slot start before the earliest week start");

  a_negative_only_week: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_slot_start < 33'sd0)) |->
      ($past(in_period_kind, LAT) == cpsi_pkg::KIND_WEEK))
    else $error("negative slot start outside a week transaction");

endmodule

bind calendar_period_slot_index cpsi_check u_cpsi_check (.*);
